### design/i2cms_pkg.sv
// i2cms_pkg: shared codes, constants and the result beat type of the
// i2c master bit sequencer. No dependencies.

package i2cms_pkg;

   // operation codes on the request channel
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // register indexes (byte address 4*i)
   localparam int          ADDR_W     = 3;
   localparam logic        REG_DELAY  = 1'b0;
   localparam logic        REG_ENABLE = 1'b1;
   localparam logic [15:0] DELAY_RESET = 16'd1000;

   // bit positions in the line register
   localparam int L_SCL  = 0;
   localparam int L_SCLD = 1;
   localparam int L_SDA  = 2;
   localparam int L_SDAD = 3;

   // sequencer phases
   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_S1      = 5'd1;
   localparam logic [4:0] PH_S2      = 5'd2;
   localparam logic [4:0] PH_S3      = 5'd3;
   localparam logic [4:0] PH_S4      = 5'd4;
   localparam logic [4:0] PH_P1      = 5'd5;
   localparam logic [4:0] PH_P2      = 5'd6;
   localparam logic [4:0] PH_P3      = 5'd7;
   localparam logic [4:0] PH_WDATA   = 5'd8;
   localparam logic [4:0] PH_WHIGH   = 5'd9;
   localparam logic [4:0] PH_WLOW    = 5'd10;
   localparam logic [4:0] PH_WGAP    = 5'd11;
   localparam logic [4:0] PH_WACKHI  = 5'd12;
   localparam logic [4:0] PH_WACKLO  = 5'd13;
   localparam logic [4:0] PH_RREL    = 5'd14;
   localparam logic [4:0] PH_RHIGH   = 5'd15;
   localparam logic [4:0] PH_RLOW    = 5'd16;
   localparam logic [4:0] PH_RACKHI  = 5'd17;
   localparam logic [4:0] PH_RACKLO  = 5'd18;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic       scl_level;
      logic       scl_drive;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } result_type;

endpackage

### design/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: bit-level i2c master timed by request ticks.
// Depends on i2cms_pkg for codes, constants and the result beat type.
//
// Usage: every request beat is either a tick (one clock of the bus timebase,
// carrying the sampled SDA level) or a command: start, stop, write byte or
// read byte. A command is taken only while the bus is enabled and idle;
// otherwise it is dropped, but it still returns a result beat. Each request
// beat returns exactly one result beat with the line drives, busy, a done
// pulse, the last read byte and the last write ack.
// The result of an accepted beat is registered in the output register, or
// in the skid register while the output beat is held. Throughput is one
// beat per cycle while req_stall is low; the next state is formed by one
// pass of logic between the state registers and the result register.
// When the receiver stalls, one more beat is parked in a skid register;
// req_stall rises only while that skid register is full.
// Reset clears the sequencer to idle with both lines released, the delay
// unit to 1000 ticks and the bus disabled. Registers: delay unit at byte
// address 0, bus enable at 4; write them only while the block is idle.

module i2c_master_bit_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_operation,
   input  logic [7:0]                  req_command_data,
   input  logic                        req_sda_in,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_scl_level,
   output logic                        rsp_scl_drive,
   output logic                        rsp_sda_level,
   output logic                        rsp_sda_drive,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic [7:0]                  rsp_read_byte,
   output logic                        rsp_ack_seen,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [i2cms_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   // configuration
   logic [15:0] delay_ff, delay_in;
   logic        enable_ff, enable_in;

   // sequencer state
   logic [4:0]  phase_ff, phase_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [17:0] wait_ff, wait_in;
   logic        ack_out_ff, ack_out_in;
   logic [3:0]  line_ff, line_in;
   logic        last_ack_ff, last_ack_in;
   logic [7:0]  read_hold_ff, read_hold_in;
   logic        done_in;

   // result side
   i2cms_pkg::result_type out_ff, out_in, skid_ff, skid_in, res;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic        in_acc;
   logic        out_free;
   logic        cfg_wr;
   logic        cfg_idx;
   logic [17:0] unit1;
   logic [17:0] unit2;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[2];

   always_comb begin
      unique case (cfg_idx)
         i2cms_pkg::REG_DELAY:  prdata = {16'd0, delay_ff};
         i2cms_pkg::REG_ENABLE: prdata = {31'd0, enable_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign req_stall = skid_valid_ff;
   assign in_acc    = req_valid & ~skid_valid_ff;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   assign unit1 = {2'b00, delay_ff};
   assign unit2 = {1'b0, delay_ff, 1'b0};

   // next sequencer state for one request beat, then register writes
   always_comb begin
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      ack_out_in   = ack_out_ff;
      line_in      = line_ff;
      last_ack_in  = last_ack_ff;
      read_hold_in = read_hold_ff;
      delay_in     = delay_ff;
      enable_in    = enable_ff;
      done_in      = 1'b0;

      if (req_operation == i2cms_pkg::OP_TICK) begin
         if (phase_ff != i2cms_pkg::PH_IDLE) begin
            if (wait_ff > 18'd1) begin
               wait_in = wait_ff - 18'd1;
            end else begin
               wait_in = 18'd0;
               unique case (phase_ff)
                  i2cms_pkg::PH_S1: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b1;
                     phase_in = i2cms_pkg::PH_S2;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_S2: begin
                     line_in[i2cms_pkg::L_SDA] = 1'b0;
                     phase_in = i2cms_pkg::PH_S3;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_S3: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b0;
                     phase_in = i2cms_pkg::PH_S4;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_P1: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b1;
                     phase_in = i2cms_pkg::PH_P2;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_P2: begin
                     line_in[i2cms_pkg::L_SDA] = 1'b1;
                     phase_in = i2cms_pkg::PH_P3;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_WDATA: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b1;
                     phase_in = i2cms_pkg::PH_WHIGH;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_WHIGH: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b0;
                     phase_in = i2cms_pkg::PH_WLOW;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_WLOW: begin
                     if (bit_ff < i2cms_pkg::LAST_BIT) begin
                        bit_in = bit_ff + 3'd1;
                        line_in[i2cms_pkg::L_SDA] = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                        phase_in = i2cms_pkg::PH_WDATA;
                     end else begin
                        phase_in = i2cms_pkg::PH_WGAP;
                     end
                     wait_in = unit1;
                  end
                  i2cms_pkg::PH_WGAP: begin
                     // release sda for the slave ack
                     line_in[i2cms_pkg::L_SDAD] = 1'b0;
                     line_in[i2cms_pkg::L_SCL]  = 1'b1;
                     phase_in = i2cms_pkg::PH_WACKHI;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_WACKHI: begin
                     last_ack_in = req_sda_in;
                     line_in[i2cms_pkg::L_SCL] = 1'b0;
                     phase_in = i2cms_pkg::PH_WACKLO;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_WACKLO: begin
                     line_in[i2cms_pkg::L_SDA]  = 1'b1;
                     line_in[i2cms_pkg::L_SDAD] = 1'b1;
                     phase_in = i2cms_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end
                  i2cms_pkg::PH_RREL: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b1;
                     phase_in = i2cms_pkg::PH_RHIGH;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_RHIGH: begin
                     shift_in = {shift_ff[6:0], req_sda_in};
                     line_in[i2cms_pkg::L_SCL] = 1'b0;
                     phase_in = i2cms_pkg::PH_RLOW;
                     wait_in  = unit2;
                  end
                  i2cms_pkg::PH_RLOW: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b1;
                     wait_in = unit2;
                     if (bit_ff < i2cms_pkg::LAST_BIT) begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = i2cms_pkg::PH_RHIGH;
                     end else begin
                        // master drives its ack level
                        line_in[i2cms_pkg::L_SDA]  = ack_out_ff;
                        line_in[i2cms_pkg::L_SDAD] = 1'b1;
                        phase_in = i2cms_pkg::PH_RACKHI;
                     end
                  end
                  i2cms_pkg::PH_RACKHI: begin
                     line_in[i2cms_pkg::L_SCL] = 1'b0;
                     phase_in = i2cms_pkg::PH_RACKLO;
                     wait_in  = unit1;
                  end
                  i2cms_pkg::PH_RACKLO: begin
                     read_hold_in = shift_ff;
                     phase_in = i2cms_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end
                  default: begin
                     // end of start, end of stop, and unused codes
                     phase_in = i2cms_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end
               endcase
            end
         end
      end else if (req_operation <= i2cms_pkg::OP_READ && enable_ff &&
                   phase_ff == i2cms_pkg::PH_IDLE) begin
         bit_in  = 3'd0;
         wait_in = unit1;
         case (req_operation)
            i2cms_pkg::OP_START: begin
               line_in[i2cms_pkg::L_SDA]  = 1'b1;
               line_in[i2cms_pkg::L_SDAD] = 1'b1;
               phase_in = i2cms_pkg::PH_S1;
            end
            i2cms_pkg::OP_STOP: begin
               line_in[i2cms_pkg::L_SDA]  = 1'b0;
               line_in[i2cms_pkg::L_SDAD] = 1'b1;
               phase_in = i2cms_pkg::PH_P1;
            end
            i2cms_pkg::OP_WRITE: begin
               line_in[i2cms_pkg::L_SDAD] = 1'b1;
               line_in[i2cms_pkg::L_SDA]  = req_command_data[7];
               shift_in = {req_command_data[6:0], 1'b0};
               phase_in = i2cms_pkg::PH_WDATA;
            end
            default: begin
               ack_out_in = req_command_data[0];
               shift_in   = 8'd0;
               line_in[i2cms_pkg::L_SDAD] = 1'b0;
               phase_in = i2cms_pkg::PH_RREL;
            end
         endcase
      end

      // item state only moves on an accepted beat
      if (!in_acc) begin
         phase_in     = phase_ff;
         bit_in       = bit_ff;
         shift_in     = shift_ff;
         wait_in      = wait_ff;
         ack_out_in   = ack_out_ff;
         line_in      = line_ff;
         last_ack_in  = last_ack_ff;
         read_hold_in = read_hold_ff;
      end

      if (cfg_wr) begin
         unique case (cfg_idx)
            i2cms_pkg::REG_DELAY: begin
               delay_in = pwdata[15:0];
            end
            i2cms_pkg::REG_ENABLE: begin
               enable_in = pwdata[0];
               if (!pwdata[0]) begin
                  line_in[i2cms_pkg::L_SCLD] = 1'b0;
                  line_in[i2cms_pkg::L_SDAD] = 1'b0;
                  phase_in = i2cms_pkg::PH_IDLE;
                  wait_in  = 18'd0;
               end else if (!enable_ff) begin
                  line_in = 4'hF;
               end
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   always_comb begin
      res.scl_level = line_in[i2cms_pkg::L_SCL];
      res.scl_drive = line_in[i2cms_pkg::L_SCLD];
      res.sda_level = line_in[i2cms_pkg::L_SDA];
      res.sda_drive = line_in[i2cms_pkg::L_SDAD];
      res.busy_res  = (phase_in != i2cms_pkg::PH_IDLE);
      res.done_res  = done_in;
      res.read_byte = read_hold_in;
      res.ack_seen  = last_ack_in;
   end

   // output register with one skid beat
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = in_acc;
         end
      end else if (in_acc) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= i2cms_pkg::DELAY_RESET;
         enable_ff     <= 1'b0;
         phase_ff      <= i2cms_pkg::PH_IDLE;
         bit_ff        <= 3'd0;
         shift_ff      <= 8'd0;
         wait_ff       <= 18'd0;
         ack_out_ff    <= 1'b1;
         line_ff       <= 4'd0;
         last_ack_ff   <= 1'b0;
         read_hold_ff  <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         delay_ff      <= delay_in;
         enable_ff     <= enable_in;
         phase_ff      <= phase_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         wait_ff       <= wait_in;
         ack_out_ff    <= ack_out_in;
         line_ff       <= line_in;
         last_ack_ff   <= last_ack_in;
         read_hold_ff  <= read_hold_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_scl_drive = out_ff.scl_drive;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_sda_drive = out_ff.sda_drive;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_read_byte = out_ff.read_byte;
   assign rsp_ack_seen  = out_ff.ack_seen;

   // skid beat only exists behind a held output beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without output beat");

   // a finishing beat always reports the master idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done beat reports busy");

   // disabled bus never drives either line
   assert property (@(posedge clock) disable iff (reset)
      !enable_ff |-> (!line_ff[i2cms_pkg::L_SCLD] && !line_ff[i2cms_pkg::L_SDAD]))
      else $error("line driven while bus disabled");

   // no pending wait while idle
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cms_pkg::PH_IDLE) |-> (wait_ff == 18'd0))
      else $error("wait count left over in idle");

   // a stalled full pipe takes no request beat
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("skid beat dropped while stalled");

endmodule
